/* sv/wbss_pkg.sv */
// Package for the wildcard byte signature scanner.
// Holds sizes, register indexes and the structs shared by the scanner modules.
// No dependencies.
`timescale 1ns / 1ps

package wbss_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int SIG_BYTES   = 16;
	localparam int LEN_CAP     = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;
	localparam int LEN_W       = $clog2(LEN_CAP + 1);
	localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int COUNT_W     = 32;
	localparam int ADDR_W      = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int LEN_REG_W   = 5;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE         = 3'd4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [SIG_BYTES*8-1:0] sig;
		logic [SIG_BYTES-1:0]   wild;
		logic [LEN_W-1:0]       len;
		logic [ADDR_W-1:0]      base;
	} cfg_t;

	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] offset;
	} scan_result_t;

endpackage

/* sv/wildcard_byte_signature_scanner_core.sv */
// The result of a last item passes through the input register and then the result
// register before it is offered; other items give none.
// Throughput: one item per cycle; the input register and the result register
// part the two channels, so only a last item stalls behind an untaken result.
// Reset: arst_n clears the scan state and the handshake; registers take their
// reset values (pattern length 1, all others 0).
`timescale 1ns / 1ps

module wildcard_byte_signature_scanner_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [wbss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wbss_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       data_byte,
	input  logic                             last_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             found,
	output logic [wbss_pkg::ADDR_W-1:0]      match_address
);
	import wbss_pkg::*;

	cfg_t         cfg;
	scan_result_t result;

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic              found_q;
	logic [ADDR_W-1:0] match_address_q;
	logic              out_free;
	logic              advance;

	wbss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wbss_window_match u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.data_s1 (data_s1),
		.last_s1 (last_s1),
		.result  (result)
	);

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			found_q         <= result.found;
			match_address_q <= result.found ? cfg.base + ADDR_W'(result.offset) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign match_address = match_address_q;

`ifndef SYNTHESIS
	a_no_addr_without_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> match_address_q == '0)
		else $error("address given without a match");
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result without a last item");
	a_last_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && !out_ready |-> !in_ready && !advance)
		else $error("stalled last item overrun");
`endif

endmodule

/* sv/wbss_cfg_regs.sv */
// Configuration registers of the signature scanner.
// Decodes register writes and caps the pattern length; uses wbss_pkg.
`timescale 1ns / 1ps

module wbss_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [wbss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wbss_pkg::CFG_DATA_W-1:0]  cfg_data,
	output wbss_pkg::cfg_t                   cfg
);
	import wbss_pkg::*;

	logic [SIG_BYTES*8-1:0] sig_q;
	logic [SIG_BYTES-1:0]   wild_q;
	logic [LEN_W-1:0]       len_q;
	logic [ADDR_W-1:0]      base_q;
	logic [LEN_REG_W-1:0]   len_raw;
	logic [LEN_W-1:0]       len_capped;

	// zero means one, anything above the cap means the cap
	always_comb begin
		len_raw = cfg_data[LEN_REG_W-1:0];
		if (len_raw == '0) begin
			len_capped = LEN_W'(1);
		end else if (len_raw > LEN_REG_W'(LEN_CAP)) begin
			len_capped = LEN_W'(LEN_CAP);
		end else begin
			len_capped = LEN_W'(len_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q  <= '0;
			wild_q <= '0;
			len_q  <= LEN_W'(1);
			base_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:  sig_q[63:0]   <= cfg_data;
				REG_PATTERN_HIGH: sig_q[127:64] <= cfg_data;
				REG_WILDCARD:     wild_q        <= cfg_data[SIG_BYTES-1:0];
				REG_LENGTH:       len_q         <= len_capped;
				REG_BASE:         base_q        <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.sig  = sig_q;
	assign cfg.wild = wild_q;
	assign cfg.len  = len_q;
	assign cfg.base = base_q;

endmodule

/* sv/wbss_window_match.sv */
// Sliding byte window, saturating byte counter and wildcard compare.
// Records the first match of a region; uses wbss_pkg.
`timescale 1ns / 1ps

module wbss_window_match (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wbss_pkg::cfg_t         cfg,
	input  logic                   advance,
	input  logic [7:0]             data_s1,
	input  logic                   last_s1,
	output wbss_pkg::scan_result_t result
);
	import wbss_pkg::*;

	logic [7:0]         window_q [MAX_PATTERN];
	logic [7:0]         window_nxt [MAX_PATTERN];
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_nxt;
	logic               seen_q;
	logic [COUNT_W-1:0] first_offset_q;
	logic [COUNT_W-1:0] new_offset;
	logic [SIG_BYTES-1:0] pos_ok;
	logic               hit;

	always_comb begin
		window_nxt[0] = data_s1;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			window_nxt[j] = window_q[j-1];
		end
		count_nxt  = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
		new_offset = count_nxt - COUNT_W'(cfg.len);
	end

	// signature byte k sits len-1-k bytes back from the newest
	always_comb begin
		logic [IDX_W-1:0] idx;
		for (int k = 0; k < SIG_BYTES; k++) begin
			idx = IDX_W'(cfg.len) - IDX_W'(k) - IDX_W'(1);
			if (LEN_W'(k) >= cfg.len || cfg.wild[k]) begin
				pos_ok[k] = 1'b1;
			end else begin
				pos_ok[k] = (window_nxt[idx] == cfg.sig[8*k +: 8]);
			end
		end
		hit = (&pos_ok) && (count_nxt >= COUNT_W'(cfg.len));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				window_q[j] <= '0;
			end
			count_q        <= '0;
			seen_q         <= 1'b0;
			first_offset_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				for (int j = 0; j < MAX_PATTERN; j++) begin
					window_q[j] <= '0;
				end
				count_q        <= '0;
				seen_q         <= 1'b0;
				first_offset_q <= '0;
			end else begin
				window_q <= window_nxt;
				count_q  <= count_nxt;
				if (!seen_q && hit) begin
					seen_q         <= 1'b1;
					first_offset_q <= new_offset;
				end
			end
		end
	end

	assign result.found  = seen_q || hit;
	assign result.offset = seen_q ? first_offset_q : new_offset;

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> count_q == '0 && !seen_q)
		else $error("scan state not cleared after last item");
	a_first_kept: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q && advance && !last_s1 |=> $stable(first_offset_q) && seen_q)
		else $error("first match offset overwritten");
`endif

endmodule
